### src/delayed_spiking_neuron_step_core_defines.svh
// Assertion macros used by the checker module dsn_checker
`ifndef DELAYED_SPIKING_NEURON_STEP_CORE_DEFINES_SVH
`define DELAYED_SPIKING_NEURON_STEP_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define DSN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define DSN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/dsn_pkg.sv
package dsn_pkg;

   // default sizes
   localparam int NEURONS_DEF   = 256;
   localparam int SYN_SLOTS_DEF = 16;
   localparam int MAX_STEPS_DEF = 256;

   // port widths
   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // command queue depth
   localparam int QDEPTH = 4;

   // item kinds
   localparam logic [1:0] KIND_LOAD_NEURON = 2'd0;
   localparam logic [1:0] KIND_LOAD_SYN    = 2'd1;
   localparam logic [1:0] KIND_EVAL        = 2'd2;
   localparam logic [1:0] KIND_UNUSED      = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_LEAK     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTING_FLOOR = 1'b1;

   // one classified word between front and back
   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         neuron;
      logic [3:0]         slot;
      logic [7:0]         source_neuron;
      logic [7:0]         delay_steps;
      logic signed [15:0] weight;
      logic signed [15:0] threshold;
      logic               input_flag;
      logic [4:0]         synapse_count;
      logic [7:0]         timestep;
      logic signed [15:0] external_spike;
   } cmd_type;

   // configuration seen by the back end
   typedef struct packed {
      logic               full_leak;
      logic signed [31:0] resting_floor;
   } cfg_type;

   // neuron table entry
   typedef struct packed {
      logic signed [15:0] threshold;
      logic               input_flag;
      logic [4:0]         synapse_count;
   } ntab_type;

   // synapse table entry
   typedef struct packed {
      logic [7:0]         source_neuron;
      logic [7:0]         delay_steps;
      logic signed [15:0] weight;
   } syn_type;

endpackage

### src/delayed_spiking_neuron_step_core.sv
// Loads are written in the back end as they are popped; an evaluate walks the
// synapse table over its clamped synapse count, one synapse read and one spike
// history read per synapse, then integrates, writes back and posts the result.
// The write back waits while a stalled result word still occupies the output.
// Reset is synchronous, active high; after it all NEURONS*MAX_STEPS spike history
// entries (65536 by default) are swept to zero, with req_tready low.
module delayed_spiking_neuron_step_core
   import dsn_pkg::*;
#(
   parameter int NEURONS   = NEURONS_DEF,
   parameter int SYN_SLOTS = SYN_SLOTS_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // neuron, slot, source_neuron, delay_steps, weight, threshold,
   // input_flag, synapse_count, timestep, external_spike, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // neuron_out, spiked, pre_reset_potential, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    q_empty;
   logic    q_push;
   logic    q_pop;
   cmd_type q_wdata;
   cmd_type q_rdata;
   logic    clearing;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FULL_LEAK:     cfg_in.full_leak     = csr_wdata[0];
            CSR_RESTING_FLOOR: cfg_in.resting_floor = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsn_front #(
      .NEURONS   (NEURONS),
      .SYN_SLOTS (SYN_SLOTS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .clearing   (clearing),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   dsn_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   dsn_back #(
      .NEURONS   (NEURONS),
      .SYN_SLOTS (SYN_SLOTS),
      .MAX_STEPS (MAX_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### src/dsn_front.sv
module dsn_front
   import dsn_pkg::*;
#(
   parameter int NEURONS   = NEURONS_DEF,
   parameter int SYN_SLOTS = SYN_SLOTS_DEF
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  q_full,
   input  logic                  clearing,
   output logic                  q_push,
   output cmd_type               q_wdata
);

   logic    accept;
   logic    keep;
   cmd_type cmd;

   // unpack the word
   always_comb begin
      cmd.kind           = req_tuser;
      cmd.neuron         = req_tdata[7:0];
      cmd.slot           = req_tdata[11:8];
      cmd.source_neuron  = req_tdata[19:12];
      cmd.delay_steps    = req_tdata[27:20];
      cmd.weight         = req_tdata[43:28];
      cmd.threshold      = req_tdata[59:44];
      cmd.input_flag     = req_tdata[60];
      cmd.synapse_count  = req_tdata[65:61];
      cmd.timestep       = req_tdata[73:66];
      cmd.external_spike = req_tdata[89:74];
   end

   // classify: drop unused kinds and out-of-range targets
   always_comb begin
      keep = 1'b0;
      if (32'(cmd.neuron) < NEURONS) begin
         unique case (cmd.kind)
            KIND_LOAD_NEURON: keep = 1'b1;
            KIND_LOAD_SYN:    keep = (32'(cmd.slot) < SYN_SLOTS);
            KIND_EVAL:        keep = 1'b1;
            default:          keep = 1'b0;
         endcase
      end
   end

   assign req_tready = !q_full && !clearing;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && keep;
   assign q_wdata    = cmd;

endmodule

### src/dsn_queue.sv
module dsn_queue
   import dsn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   input  logic    pop,
   output cmd_type rdata,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(QDEPTH);

   cmd_type              mem_ff [QDEPTH];
   logic [PTR_W-1:0]     wptr_ff, wptr_in;
   logic [PTR_W-1:0]     rptr_ff, rptr_in;
   logic [PTR_W:0]       cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (cnt_ff == (PTR_W+1)'(QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   // pointer and fill count
   always_comb begin
      wptr_in = wptr_ff + PTR_W'(do_push);
      rptr_in = rptr_ff + PTR_W'(do_pop);
      cnt_in  = cnt_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

### src/dsn_back.sv
module dsn_back
   import dsn_pkg::*;
#(
   parameter int NEURONS   = NEURONS_DEF,
   parameter int SYN_SLOTS = SYN_SLOTS_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_empty,
   input  cmd_type               q_rdata,
   output logic                  q_pop,
   output logic                  clearing,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int NIDX_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int SDEPTH  = NEURONS * SYN_SLOTS;
   localparam int SADDR_W = $clog2(SDEPTH);
   localparam int HDEPTH  = NEURONS * MAX_STEPS;
   localparam int HADDR_W = $clog2(HDEPTH);
   localparam int CNT_W   = $clog2(SYN_SLOTS + 1);
   localparam int SLOT_W  = (SYN_SLOTS > 1) ? $clog2(SYN_SLOTS) : 1;
   localparam int TOT_W   = 18 + CNT_W;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_NRD   = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_FIN   = 6'b010000,
      ST_WB    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // memories
   ntab_type          ntab_mem [NEURONS];
   syn_type           syn_mem  [SDEPTH];
   logic signed [31:0] pot_mem [NEURONS];
   logic              hist_mem [HDEPTH];

   ntab_type           ntab_rd_ff;
   syn_type            syn_rd_ff;
   logic signed [31:0] pot_rd_ff;
   logic               pot_vld_rd_ff;
   logic               hist_rd_ff;
   logic [NEURONS-1:0] pot_valid_ff, pot_valid_in;

   // memory control
   logic               ntab_we;
   logic               syn_we;
   logic [SADDR_W-1:0] syn_waddr;
   logic [SADDR_W-1:0] syn_raddr;
   logic               pot_we;
   logic [NIDX_W-1:0]  pot_waddr;
   logic [NIDX_W-1:0]  head_idx;
   logic               hist_we;
   logic               hist_wdata;
   logic [HADDR_W-1:0] hist_waddr;
   logic [HADDR_W-1:0] hist_raddr;

   // item state
   logic [HADDR_W-1:0]      clr_ff, clr_in;
   logic [7:0]              n_ff, n_in;
   logic [7:0]              t_ff, t_in;
   logic signed [15:0]      ext_ff, ext_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [15:0]      thr_ff, thr_in;
   logic signed [31:0]      pot_ff, pot_in;
   logic signed [TOT_W-1:0] total_ff, total_in;
   logic                    event_ff, event_in;
   logic [CNT_W-1:0]        iss_ff, iss_in;
   logic                    s1_v_ff, s1_v_in;
   logic                    s2_v_ff, s2_v_in;
   logic                    s2_ok_ff, s2_ok_in;
   logic signed [15:0]      s2_w_ff, s2_w_in;
   logic signed [31:0]      v_ff, v_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // walk and finish datapath
   logic                    syn_ok;
   logic [7:0]              syn_st;
   logic [CNT_W-1:0]        cnt_clamped;
   logic signed [31:0]      base;
   logic signed [31:0]      floored;
   logic signed [33:0]      sum;
   logic                    fired;
   logic                    out_free;

   assign head_idx    = NIDX_W'(q_rdata.neuron);
   assign syn_raddr   = SADDR_W'(n_ff) * SADDR_W'(SYN_SLOTS)
                      + SADDR_W'(iss_ff[SLOT_W-1:0]);
   assign syn_st      = t_ff - syn_rd_ff.delay_steps;
   assign syn_ok      = (syn_rd_ff.delay_steps <= t_ff)
                      && (32'(syn_rd_ff.source_neuron) < NEURONS)
                      && (32'(syn_st) < MAX_STEPS);
   assign hist_raddr  = HADDR_W'(syn_rd_ff.source_neuron) * HADDR_W'(MAX_STEPS)
                      + HADDR_W'(syn_st);
   assign cnt_clamped = (32'(ntab_rd_ff.synapse_count) > SYN_SLOTS)
                      ? CNT_W'(SYN_SLOTS) : CNT_W'(ntab_rd_ff.synapse_count);
   assign base        = cfg.full_leak ? 32'sd0 : pot_ff;
   assign floored     = (base < cfg.resting_floor) ? cfg.resting_floor : base;
   assign sum         = 34'(floored) + 34'(total_ff);
   assign fired       = event_ff && (v_ff >= 32'(thr_ff));
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign clearing    = (state_ff == ST_CLEAR);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      ext_in       = ext_ff;
      cnt_in       = cnt_ff;
      thr_in       = thr_ff;
      pot_in       = pot_ff;
      total_in     = total_ff;
      event_in     = event_ff;
      iss_in       = iss_ff;
      s1_v_in      = 1'b0;
      s2_v_in      = 1'b0;
      s2_ok_in     = s2_ok_ff;
      s2_w_in      = s2_w_ff;
      v_in         = v_ff;
      pot_valid_in = pot_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      ntab_we      = 1'b0;
      syn_we       = 1'b0;
      syn_waddr    = SADDR_W'(head_idx) * SADDR_W'(SYN_SLOTS)
                   + SADDR_W'(q_rdata.slot);
      pot_we       = 1'b0;
      pot_waddr    = NIDX_W'(n_ff);
      hist_we      = 1'b0;
      hist_wdata   = 1'b0;
      hist_waddr   = HADDR_W'(n_ff) * HADDR_W'(MAX_STEPS) + HADDR_W'(t_ff);

      unique case (state_ff)
         // sweep spike history to zero after reset
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            clr_in     = clr_ff + HADDR_W'(1);
            if (clr_ff == HADDR_W'(HDEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take the next command
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_rdata.kind)
                  KIND_LOAD_NEURON: ntab_we = 1'b1;
                  KIND_LOAD_SYN:    syn_we  = 1'b1;
                  KIND_EVAL: begin
                     n_in     = q_rdata.neuron;
                     t_in     = q_rdata.timestep;
                     ext_in   = q_rdata.external_spike;
                     state_in = ST_NRD;
                  end
                  default: ;
               endcase
            end
         end
         // neuron entry and potential are in
         ST_NRD: begin
            cnt_in   = cnt_clamped;
            thr_in   = ntab_rd_ff.threshold;
            pot_in   = (t_ff == 8'd0 || !pot_vld_rd_ff) ? 32'sd0 : pot_rd_ff;
            total_in = ntab_rd_ff.input_flag ? TOT_W'(ext_ff) : '0;
            event_in = ntab_rd_ff.input_flag && (ext_ff != 16'sd0);
            iss_in   = '0;
            state_in = ST_WALK;
         end
         // synapse read, history read, accumulate
         ST_WALK: begin
            if (iss_ff < cnt_ff) begin
               s1_v_in = 1'b1;
               iss_in  = iss_ff + CNT_W'(1);
            end
            if (s1_v_ff) begin
               s2_v_in  = 1'b1;
               s2_ok_in = syn_ok;
               s2_w_in  = syn_rd_ff.weight;
            end
            if (s2_v_ff && s2_ok_ff && hist_rd_ff) begin
               total_in = total_ff + TOT_W'(s2_w_ff);
               event_in = 1'b1;
            end
            if (iss_ff == cnt_ff && !s1_v_ff && !s2_v_ff) begin
               state_in = ST_FIN;
            end
         end
         // on an event, integrate with leak, floor and saturation; else keep the potential
         ST_FIN: begin
            if (!event_ff) begin
               v_in = pot_ff;
            end else if (sum > 34'sd2147483647) begin
               v_in = 32'sh7FFFFFFF;
            end else if (sum < -34'sd2147483648) begin
               v_in = 32'sh80000000;
            end else begin
               v_in = 32'(sum);
            end
            state_in = ST_WB;
         end
         // write back and post the result
         ST_WB: begin
            if (out_free) begin
               pot_we                       = 1'b1;
               pot_valid_in[NIDX_W'(n_ff)]  = 1'b1;
               hist_we                      = (32'(t_ff) < MAX_STEPS);
               hist_wdata                   = fired;
               rsp_valid_in                 = 1'b1;
               rsp_data_in                  = {7'd0, v_ff, fired, n_ff};
               state_in                     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         pot_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         pot_valid_ff <= pot_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      t_ff        <= t_in;
      ext_ff      <= ext_in;
      cnt_ff      <= cnt_in;
      thr_ff      <= thr_in;
      pot_ff      <= pot_in;
      total_ff    <= total_in;
      event_ff    <= event_in;
      iss_ff      <= iss_in;
      s2_ok_ff    <= s2_ok_in;
      s2_w_ff     <= s2_w_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
   end

   // neuron table
   always_ff @(posedge clock) begin
      if (ntab_we) begin
         ntab_mem[head_idx] <= '{threshold:     q_rdata.threshold,
                                 input_flag:    q_rdata.input_flag,
                                 synapse_count: q_rdata.synapse_count};
      end
      ntab_rd_ff <= ntab_mem[head_idx];
   end

   // synapse table
   always_ff @(posedge clock) begin
      if (syn_we) begin
         syn_mem[syn_waddr] <= '{source_neuron: q_rdata.source_neuron,
                                 delay_steps:   q_rdata.delay_steps,
                                 weight:        q_rdata.weight};
      end
      syn_rd_ff <= syn_mem[syn_raddr];
   end

   // potentials, with per-entry valid bits
   always_ff @(posedge clock) begin
      if (pot_we) begin
         pot_mem[pot_waddr] <= fired ? 32'sd0 : v_ff;
      end
      pot_rd_ff     <= pot_mem[head_idx];
      pot_vld_rd_ff <= pot_valid_ff[head_idx];
   end

   // spike history
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[hist_raddr];
   end

endmodule

### src/dsn_checker.sv
`include "delayed_spiking_neuron_step_core_defines.svh"

module dsn_checker
   import dsn_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   `DSN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // fill bits of a result are zero
   `DSN_ASSERT_NOW(a_rsp_fill, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:41] == '0)

   // no result right after reset
   `DSN_ASSERT_NOW(a_rsp_reset, clock, reset, $past(reset), !rsp_tvalid)

   // history sweep keeps the input closed right after reset
   `DSN_ASSERT_NOW(a_req_clear, clock, reset, $past(reset), !req_tready)

endmodule

bind delayed_spiking_neuron_step_core dsn_checker u_dsn_checker (.*);

### bench/delayed_spiking_neuron_step_core_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and register ports, keeps its own copy of the
// network state and compares every response word with the predicted outcome.
module delayed_spiking_neuron_step_core_checker
   import dsn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending,
   output int                    results
);

   typedef struct packed {
      logic [7:0]         neuron;
      logic               spiked;
      logic signed [31:0] potential;
   } outcome_type;

   // network state mirror
   int                 potential_mem [256];
   bit                 fired_hist    [256][256];
   logic signed [15:0] thresh_mem    [256];
   bit                 ext_ok_mem    [256];
   logic [4:0]         count_mem     [256];
   logic [7:0]         src_mem       [4096];
   logic [7:0]         delay_mem     [4096];
   logic signed [15:0] weight_mem    [4096];
   bit                 leak_on;
   logic signed [31:0] floor_val;

   outcome_type outcome_q[$];

   // integrate one evaluate word and queue its outcome
   task automatic integrate_neuron(input logic [7:0] n, input logic [7:0] t,
                                   input logic signed [15:0] ext);
      longint      v;
      longint      total;
      longint      st;
      bit          ev;
      bit          fire;
      int          walk;
      int          k;
      outcome_type o;
      v     = (t == 0) ? 0 : longint'(potential_mem[n]);
      total = 0;
      ev    = 0;
      walk  = (count_mem[n] > 16) ? 16 : count_mem[n];
      if (ext_ok_mem[n]) begin
         if (ext != 0) ev = 1;
         total += longint'(ext);
      end
      for (int i = 0; i < walk; i++) begin
         k  = n * 16 + i;
         st = longint'(t) - longint'(delay_mem[k]);
         if (st >= 0 && fired_hist[src_mem[k]][st]) begin
            ev = 1;
            total += longint'(weight_mem[k]);
         end
      end
      if (ev) begin
         if (leak_on) v = 0;
         if (v < longint'(floor_val)) v = longint'(floor_val);
         v += total;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      fire = ev && (v >= longint'(thresh_mem[n]));
      potential_mem[n] = fire ? 0 : int'(v);
      fired_hist[n][t] = fire;
      o.neuron    = n;
      o.spiked    = fire;
      o.potential = v[31:0];
      outcome_q.push_back(o);
   endtask

   outcome_type got;
   outcome_type want;
   int          k_idx;

   always @(posedge clock) begin
      if (reset) begin
         foreach (potential_mem[i]) potential_mem[i] = 0;
         foreach (fired_hist[i, j]) fired_hist[i][j] = 0;
         leak_on   = 0;
         floor_val = 0;
         errors    = 0;
         results   = 0;
         outcome_q.delete();
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_FULL_LEAK) leak_on = csr_wdata[0];
            else if (csr_index == CSR_RESTING_FLOOR) floor_val = csr_wdata;
         end
         // accepted request word
         if (req_tvalid && req_tready) begin
            k_idx = req_tdata[7:0] * 16 + req_tdata[11:8];
            case (req_tuser)
               KIND_LOAD_NEURON: begin
                  thresh_mem[req_tdata[7:0]] = req_tdata[59:44];
                  ext_ok_mem[req_tdata[7:0]] = req_tdata[60];
                  count_mem[req_tdata[7:0]]  = req_tdata[65:61];
               end
               KIND_LOAD_SYN: begin
                  src_mem[k_idx]    = req_tdata[19:12];
                  delay_mem[k_idx]  = req_tdata[27:20];
                  weight_mem[k_idx] = req_tdata[43:28];
               end
               KIND_EVAL:
                  integrate_neuron(req_tdata[7:0], req_tdata[73:66], req_tdata[89:74]);
               default: ;
            endcase
         end
         // accepted response word
         if (rsp_tvalid && rsp_tready) begin
            got.neuron    = rsp_tdata[7:0];
            got.spiked    = rsp_tdata[8];
            got.potential = rsp_tdata[40:9];
            results++;
            if (outcome_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response word with no outcome pending: n=%0d s=%0d v=%0d",
                           $realtime, got.neuron, got.spiked, got.potential);
            end else begin
               want = outcome_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch exp n=%0d s=%0d v=%0d, got n=%0d s=%0d v=%0d",
                              $realtime, want.neuron, want.spiked, want.potential,
                              got.neuron, got.spiked, got.potential);
               end
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

### bench/delayed_spiking_neuron_step_core_tb.sv
`timescale 1ns / 100ps

module delayed_spiking_neuron_step_core_tb;
   import dsn_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // neuron, slot, source, delay, weight, threshold,
                                       // input_flag, synapse_count, timestep, ext, zero fill
   logic [REQ_USER_W-1:0] req_tuser;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // neuron_out, spiked, pre_reset_potential, zero fill
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int errors;
   int pending;
   int results;
   int words_sent;
   int settings_run;
   int cycle_cnt;

   logic [7:0] pool [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd254, 8'd255};

   delayed_spiking_neuron_step_core DUT (.*);

   delayed_spiking_neuron_step_core_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("delayed_spiking_neuron_step_core regression: fail");
      $finish;
   end

   // mostly short gaps, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls plus one long hold-off after the sweep
   initial begin
      cycle_cnt  = 0;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         cycle_cnt++;
         if (cycle_cnt >= 67000 && cycle_cnt < 67400) rsp_tready <= 0;
         else if (cycle_cnt % 3000 < 600) rsp_tready <= 1;
         else rsp_tready <= (gap_len() == 0);
      end
   end

   // drive one request word and wait for it to be taken
   task automatic send_word(input logic [1:0] kind, input logic [89:0] fields);
      int g;
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, fields};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   // random filler so unused fields toggle too
   function automatic logic [89:0] noise();
      return 90'({$urandom, $urandom, $urandom});
   endfunction

   task automatic load_synapse(input logic [7:0] n, input logic [3:0] slot,
                               input logic [7:0] src, input logic [7:0] dly,
                               input logic [15:0] w);
      logic [89:0] f;
      f = noise();
      f[7:0] = n; f[11:8] = slot; f[19:12] = src; f[27:20] = dly; f[43:28] = w;
      send_word(KIND_LOAD_SYN, f);
   endtask

   task automatic load_neuron(input logic [7:0] n, input logic [15:0] thr,
                              input logic flag, input logic [4:0] cnt);
      logic [89:0] f;
      f = noise();
      f[7:0] = n; f[59:44] = thr; f[60] = flag; f[65:61] = cnt;
      send_word(KIND_LOAD_NEURON, f);
   endtask

   task automatic evaluate(input logic [7:0] n, input logic [7:0] t,
                           input logic [15:0] ext);
      logic [89:0] f;
      f = noise();
      f[7:0] = n; f[73:66] = t; f[89:74] = ext;
      send_word(KIND_EVAL, f);
   endtask

   // register writes only with nothing in flight
   task automatic set_regs(input logic leak, input logic [31:0] floor_v);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1; csr_index <= CSR_FULL_LEAK; csr_wdata <= {31'd0, leak};
      @(posedge clock);
      csr_index <= CSR_RESTING_FLOOR; csr_wdata <= floor_v;
      @(posedge clock);
      csr_we <= 0;
      settings_run++;
   endtask

   function automatic logic [15:0] rand_weight();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h7FFF;
      if (r == 1) return 16'h8000;
      if (r == 2) return 16'($urandom);
      return 16'($urandom_range(0, 200)) - 16'd50;
   endfunction

   function automatic logic [15:0] rand_ext();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 16'd0;
      if (r == 5) return 16'h7FFF;
      if (r == 6) return 16'h8000;
      if (r == 7) return 16'($urandom);
      return 16'($urandom_range(0, 100)) - 16'd20;
   endfunction

   // wire up the pool with all sixteen slots loaded, then step timesteps
   task automatic run_phase(input int t0, input int steps);
      logic [7:0] dly;
      logic [15:0] thr;
      int r;
      int ord;
      foreach (pool[i]) begin
         for (int s = 0; s < 16; s++) begin
            r = $urandom_range(0, 9);
            dly = (r == 0) ? 8'd255 : (r == 1) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 3));
            load_synapse(pool[i], s[3:0], pool[$urandom_range(0, 7)], dly, rand_weight());
         end
         r   = $urandom_range(0, 9);
         thr = (r == 0) ? 16'h7FFF : (r == 1) ? 16'h8000 : 16'($urandom_range(0, 220)) - 16'd20;
         load_neuron(pool[i], thr, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
      end
      for (int t = t0; t < t0 + steps; t++) begin
         ord = $urandom_range(0, 7);
         for (int j = 0; j < 8; j++) begin
            evaluate(pool[(j + ord) % 8], t[7:0], rand_ext());
            r = $urandom_range(0, 19);
            // noise: ignored kind, loads elsewhere, reloads of pool slots
            if (r == 0) send_word(KIND_UNUSED, noise());
            else if (r == 1) load_neuron(8'($urandom_range(6, 253)), 16'($urandom),
                                         1'($urandom), 5'($urandom));
            else if (r == 2) load_synapse(8'($urandom), 4'($urandom), 8'($urandom),
                                          8'($urandom), 16'($urandom));
            else if (r == 3) load_synapse(pool[$urandom_range(0, 7)], 4'($urandom),
                                          pool[$urandom_range(0, 7)], 8'($urandom_range(1, 4)),
                                          rand_weight());
         end
      end
   endtask

   initial begin
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 0;
      csr_index  = '0;
      csr_wdata  = '0;
      words_sent   = 0;
      settings_run = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      set_regs(1'b0, 32'd0);

      // directed: timestep zero, delay beyond timestep, count over sixteen, extremes
      for (int s = 0; s < 16; s++)
         load_synapse(8'd7, s[3:0], 8'd6, (s == 0) ? 8'd255 : 8'd1, 16'h7FFF);
      load_neuron(8'd6, 16'h8000, 1'b1, 5'd0);
      load_neuron(8'd7, 16'h7FFF, 1'b1, 5'd31);
      send_word(KIND_UNUSED, noise());
      evaluate(8'd6, 8'd0, 16'h7FFF);
      evaluate(8'd7, 8'd0, 16'h0000);
      evaluate(8'd6, 8'd1, 16'h8000);
      evaluate(8'd7, 8'd1, 16'h8000);
      evaluate(8'd7, 8'd255, 16'h7FFF);

      run_phase(0, 16);
      set_regs(1'b1, 32'h80000000);
      run_phase($urandom_range(20, 200), 16);
      set_regs(1'b0, 32'h7FFFFFFF);
      run_phase($urandom_range(20, 200), 16);
      set_regs(1'b0, -32'sd1000);
      run_phase($urandom_range(20, 200), 16);
      set_regs(1'b1, 32'd500);
      run_phase(240, 16);

      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d request words and %0d neuron outcomes", words_sent, results);
      $display("over %0d register settings, including both floor extremes", settings_run);
      if (errors == 0 && pending == 0)
         $display("delayed_spiking_neuron_step_core regression: pass");
      else
         $display("delayed_spiking_neuron_step_core regression: fail");
      $finish;
   end

endmodule
